@@ hdl/sliding_median_filter_mirror_assert.svh @@
// Assertion macros used by the port-level checker of the median filter.
`ifndef SLIDING_MEDIAN_FILTER_MIRROR_ASSERT_SVH
`define SLIDING_MEDIAN_FILTER_MIRROR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SMF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is high.
`define SMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ hdl/smf_pkg.sv @@
`default_nettype none

package smf_pkg;

  // Fixed field widths of the sample stream and the register port.
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 3;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;

  // The half width register and its value after reset.
  localparam logic             REG_HALF_WIDTH   = 1'b0;
  localparam logic [CFG_W-1:0] HALF_WIDTH_RESET = 3'd2;

  // Broadcast from the controller to every sorting cell.
  typedef struct packed {
    logic                       en;
    logic                       first;
    logic signed [SAMPLE_W-1:0] x;
  } feed_t;

  // What a cell hands to its right-hand neighbour.
  typedef struct packed {
    logic                       lt;
    logic                       vld;
    logic signed [SAMPLE_W-1:0] val;
  } link_t;

endpackage

`default_nettype wire

@@ hdl/sliding_median_filter_mirror.sv @@
// Channel   | Handshake           | Payload
// ----------+---------------------+-----------------------------
// input     | in_valid / in_stall | sample[15:0] signed, last
// output    | out_valid/out_stall | filtered[15:0] signed, last_res
// register  | APB psel/penable    | half_width at byte address 0
//
// A sample that completes no output leaves the block idle. Each output is
// built from 2h+1 insertions into the row of sorting cells and a load of the
// output register, h being the half width; the input is stalled meanwhile.
// A full output register that is stalled holds the block in its load step.
// Reset is synchronous; it clears the controller and sets half_width to 2.
`default_nettype none

module sliding_median_filter_mirror #(
  parameter int MAX_HALF_WIDTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [smf_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [smf_pkg::SAMPLE_W-1:0] filtered,
  output logic                                last_res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [smf_pkg::PADDR_W-1:0]         paddr,
  input  logic [smf_pkg::PDATA_W-1:0]         pwdata,
  output logic [smf_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int HW    = $clog2(MAX_HALF_WIDTH + 1);
  localparam int AW    = IW + 2;

  typedef enum logic [1:0] {S_IDLE, S_FEED, S_DONE} state_t;

  state_t                              state;
  logic [smf_pkg::CFG_W-1:0]           half_width;
  logic [HW-1:0]                       h_eff;
  logic [HW-1:0]                       hcur;
  logic [CW-1:0]                       seen_count;
  logic [CW-1:0]                       cnt_inc;
  logic [IW-1:0]                       m;
  logic [IW-1:0]                       m_new;
  logic [IW-1:0]                       h_ext;
  logic [IW-1:0]                       pos;
  logic [IW-1:0]                       jj;
  logic [IW-1:0]                       two_h;
  logic [IW-1:0]                       d;
  logic                                at_end;
  logic                                in_acc;
  logic                                cfg_wr;
  logic signed [AW-1:0]                a_raw;
  logic signed [AW-1:0]                a_abs;
  logic signed [AW-1:0]                a_mir;
  logic signed [AW-1:0]                a_clp;
  logic signed [AW-1:0]                m_s;
  logic signed [smf_pkg::SAMPLE_W-1:0] history [DEPTH];
  logic signed [smf_pkg::SAMPLE_W-1:0] cell_val [DEPTH];
  smf_pkg::feed_t                      feed;
  smf_pkg::link_t                      links [DEPTH+1];

  // Register port: every write completes in its access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[smf_pkg::PADDR_W-1] == smf_pkg::REG_HALF_WIDTH);
  assign prdata = (paddr[smf_pkg::PADDR_W-1] == smf_pkg::REG_HALF_WIDTH) ?
                  smf_pkg::PDATA_W'(half_width) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= smf_pkg::HALF_WIDTH_RESET;
    end else if (cfg_wr) begin
      half_width <= pwdata[smf_pkg::CFG_W-1:0];
    end
  end

  // Half widths above the supported maximum act as the maximum.
  always_comb begin
    if (int'(half_width) > MAX_HALF_WIDTH) begin
      h_eff = HW'(MAX_HALF_WIDTH);
    end else begin
      h_eff = HW'(half_width);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Sample history, newest first.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      history[0] <= sample;
      for (int k = 1; k < DEPTH; k++) begin
        history[k] <= history[k-1];
      end
    end
  end

  // Position of the newest sample once this transaction is counted.
  assign cnt_inc = (seen_count < CW'(DEPTH)) ? seen_count + CW'(1) : seen_count;
  assign m_new   = IW'(cnt_inc - CW'(1));
  assign h_ext   = IW'(h_eff);
  assign two_h   = IW'({hcur, 1'b0});

  // Window tap to history age, with mirroring at both ends of the signal
  // and clamping for signals shorter than the window.
  always_comb begin
    m_s   = signed'(AW'(m));
    a_raw = signed'(AW'(pos) + AW'(jj) - AW'(hcur));
    a_abs = (a_raw < 0) ? -a_raw : a_raw;
    a_mir = (at_end && (a_abs > m_s)) ? (m_s + m_s) - a_abs : a_abs;
    if (a_mir < 0) begin
      a_clp = '0;
    end else if (a_mir > m_s) begin
      a_clp = m_s;
    end else begin
      a_clp = a_mir;
    end
    d = m - a_clp[IW-1:0];
  end

  // One window sample is inserted into the sorting row per cycle.
  assign feed.en    = (state == S_FEED);
  assign feed.first = (jj == '0);
  assign feed.x     = history[d];

  assign links[0] = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    smf_sort_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .feed  (feed),
      .left  (links[k]),
      .right (links[k+1])
    );
    assign cell_val[k] = links[k+1].val;
  end

  // Controller and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seen_count <= '0;
      out_valid  <= 1'b0;
      at_end     <= 1'b0;
      jj         <= '0;
    end else begin
      // The load step decides the output register itself.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            m    <= m_new;
            hcur <= h_eff;
            jj   <= '0;
            if (last) begin
              seen_count <= '0;
              at_end     <= 1'b1;
              pos        <= (m_new > h_ext) ? m_new - h_ext : '0;
              state      <= S_FEED;
            end else begin
              seen_count <= cnt_inc;
              at_end     <= 1'b0;
              pos        <= m_new - h_ext;
              if (m_new >= h_ext) begin
                state <= S_FEED;
              end
            end
          end
        end
        S_FEED: begin
          jj <= jj + IW'(1);
          if (jj == two_h) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            filtered  <= cell_val[IW'(hcur)];
            last_res  <= at_end && (pos == m);
            if (at_end && (pos != m)) begin
              pos   <= pos + IW'(1);
              jj    <= '0;
              state <= S_FEED;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/smf_sort_cell.sv @@
`default_nettype none

// One cell of the insertion sorter. The row of cells keeps its values in
// ascending order; an empty cell counts as larger than any sample.
module smf_sort_cell (
  input  logic            clk,
  input  logic            rst,
  input  smf_pkg::feed_t  feed,
  input  smf_pkg::link_t  left,
  output smf_pkg::link_t  right
);

  logic signed [smf_pkg::SAMPLE_W-1:0] val;
  logic                                vld;
  logic                                eff_vld;

  // The first insertion of a window treats every cell as empty.
  assign eff_vld = vld && !feed.first;

  // Tell the neighbour whether the new sample goes at or before this cell.
  assign right.lt  = !eff_vld || ($signed(feed.x) < val);
  assign right.vld = eff_vld;
  assign right.val = val;

  // Shift right when the sample lands further left, take it when it lands
  // here, otherwise hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (feed.en) begin
      if (left.lt) begin
        val <= left.val;
        vld <= left.vld;
      end else if (right.lt) begin
        val <= feed.x;
        vld <= 1'b1;
      end else begin
        vld <= eff_vld;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/smf_checker.sv @@
`default_nettype none

`include "sliding_median_filter_mirror_assert.svh"

// Port-level checks on the median filter.
module smf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic signed [smf_pkg::SAMPLE_W-1:0] sample,
  input logic                                last,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [smf_pkg::SAMPLE_W-1:0] filtered,
  input logic                                last_res,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [smf_pkg::PADDR_W-1:0]         paddr,
  input logic [smf_pkg::PDATA_W-1:0]         pwdata,
  input logic [smf_pkg::PDATA_W-1:0]         prdata,
  input logic                                pready
);

  // A stalled result keeps its contents.
  `SMF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(filtered) && $stable(last_res))

  // A last sample always yields a result, so the input stays stalled after it is accepted.
  `SMF_ASSERT_NEXT(a_last_busy, clk, rst, in_valid && !in_stall && last, in_stall ##1 in_stall)

  // A new result is only loaded while the input side is held off.
  `SMF_ASSERT_IMPL(a_out_from_busy, clk, rst, $rose(out_valid), $past(in_stall))

endmodule

bind sliding_median_filter_mirror smf_checker u_smf_checker (.*);

`default_nettype wire

@@ tb/smf_checker.sv @@
`timescale 1ns / 1ps

module smf_scoreboard #(
  parameter int MAX_HALF_WIDTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [smf_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [smf_pkg::SAMPLE_W-1:0] filtered,
  input  logic                                last_res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [smf_pkg::PADDR_W-1:0]         paddr,
  input  logic [smf_pkg::PDATA_W-1:0]         pwdata,
  input  logic                                pready,
  output int                                  errors,
  output int                                  outstanding
);

  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam logic [smf_pkg::PADDR_W-1:0] HALF_WIDTH_ADDR = {smf_pkg::REG_HALF_WIDTH, 2'b00};

  // One predicted filter output.
  typedef struct packed {
    logic signed [smf_pkg::SAMPLE_W-1:0] value;
    logic                                tail;
  } median_t;

  // Mirror of the filter state: sample history (newest first), fill level and
  // the half width register.
  logic signed [smf_pkg::SAMPLE_W-1:0] sample_hist [DEPTH];
  int                                  fill;
  logic [smf_pkg::CFG_W-1:0]           half_cfg;
  median_t                             medians_q [$];

  // Median of the window centred on pos; m is the index of the newest sample.
  // Positions beyond the newest sample are mirrored only at the signal end, and
  // anything still outside the signal is clamped to the nearest end.
  function automatic logic signed [smf_pkg::SAMPLE_W-1:0] mirrored_median(
    int pos, int m, int h, bit at_end);
    logic signed [smf_pkg::SAMPLE_W-1:0] win [DEPTH];
    logic signed [smf_pkg::SAMPLE_W-1:0] v;
    int a;
    int d;
    int k;
    for (int j = -h; j <= h; j++) begin
      a = pos + j;
      if (a < 0) a = -a;
      if (at_end && a > m) a = 2 * m - a;
      if (a < 0) a = 0;
      if (a > m) a = m;
      d = m - a;
      if (d > DEPTH - 1) d = DEPTH - 1;
      win[j + h] = sample_hist[d];
    end
    // Insertion sort of the window.
    for (int j = 1; j < 2 * h + 1; j++) begin
      v = win[j];
      k = j - 1;
      while (k >= 0 && win[k] > v) begin
        win[k + 1] = win[k];
        k--;
      end
      win[k + 1] = v;
    end
    return win[h];
  endfunction

  // Shifts one accepted sample in and queues the outputs it completes.
  task automatic absorb_sample(input logic signed [smf_pkg::SAMPLE_W-1:0] s,
                               input logic is_last);
    int h;
    int m;
    int first;
    h = (half_cfg > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : int'(half_cfg);
    for (int k = DEPTH - 1; k > 0; k--) sample_hist[k] = sample_hist[k - 1];
    sample_hist[0] = s;
    if (fill < DEPTH) fill++;
    m = fill - 1;
    if (!is_last) begin
      if (m - h >= 0) medians_q.push_back('{mirrored_median(m - h, m, h, 1'b0), 1'b0});
    end else begin
      // The last sample flushes every pending position.
      first = (m - h < 0) ? 0 : m - h;
      for (int p = first; p <= m; p++)
        medians_q.push_back('{mirrored_median(p, m, h, 1'b1), p == m});
      fill = 0;
    end
  endtask

  // Watch both channels and the register port on every rising edge.
  always @(posedge clk) begin
    median_t want;
    if (rst) begin
      fill = 0;
      half_cfg = smf_pkg::HALF_WIDTH_RESET;
      medians_q.delete();
      errors = 0;
      for (int k = 0; k < DEPTH; k++) sample_hist[k] = '0;
    end else begin
      // Compare an output transaction with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (medians_q.size() == 0) begin
          $display("%0t: unexpected output: expected none, actual filtered %0d last_res %0b",
                   $time, filtered, last_res);
          errors++;
        end else begin
          want = medians_q.pop_front();
          if (filtered !== want.value) begin
            $display("%0t: filtered expected %0d actual %0d", $time, want.value, filtered);
            errors++;
          end
          if (last_res !== want.tail) begin
            $display("%0t: last_res expected %0b actual %0b", $time, want.tail, last_res);
            errors++;
          end
        end
      end
      // Predict from an accepted input transaction.
      if (in_valid && !in_stall) absorb_sample(sample, last);
      // Track register writes.
      if (psel && penable && pwrite && pready && paddr == HALF_WIDTH_ADDR)
        half_cfg = pwdata[smf_pkg::CFG_W-1:0];
    end
    outstanding = medians_q.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int MAX_HW = 4;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS = 430;
  localparam logic [smf_pkg::PADDR_W-1:0] HALF_WIDTH_ADDR = {smf_pkg::REG_HALF_WIDTH, 2'b00};

  // Flavours of random sample content.
  typedef enum int {
    MODE_WIDE,
    MODE_NARROW,
    MODE_EXTREME
  } sample_mode_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [smf_pkg::SAMPLE_W-1:0] sample = '0;
  logic                                last = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [smf_pkg::SAMPLE_W-1:0] filtered;
  logic                                last_res;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [smf_pkg::PADDR_W-1:0]         paddr = '0;
  logic [smf_pkg::PDATA_W-1:0]         pwdata = '0;
  logic [smf_pkg::PDATA_W-1:0]         prdata;
  logic                                pready;
  logic                                calm = 1'b0;
  int                                  errors;
  int                                  outstanding;
  int                                  sent = 0;

  always #5 clk = ~clk;

  sliding_median_filter_mirror #(.MAX_HALF_WIDTH(MAX_HW)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .filtered(filtered), .last_res(last_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  smf_scoreboard #(.MAX_HALF_WIDTH(MAX_HW)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .filtered(filtered), .last_res(last_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .errors(errors), .outstanding(outstanding)
  );

  // Random back-pressure on the output, switched off during the calm stretch.
  always @(posedge clk) begin
    if (rst || calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 30);
  end

  // One input transaction, preceded by a random gap outside the calm stretch.
  task automatic send_sample(input logic signed [smf_pkg::SAMPLE_W-1:0] s,
                             input logic is_last);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    last <= is_last;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Waits until every predicted output has arrived and the filter has settled.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the half width while the filter is idle; upper data bits are noise.
  task automatic set_half_width(input logic [smf_pkg::CFG_W-1:0] hw);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= HALF_WIDTH_ADDR;
    pwdata <= {(smf_pkg::PDATA_W - smf_pkg::CFG_W)'($urandom() >> smf_pkg::CFG_W), hw};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic signed [smf_pkg::SAMPLE_W-1:0] pick_sample(sample_mode_t mode);
    case (mode)
      MODE_WIDE: return (smf_pkg::SAMPLE_W)'($urandom());
      // A narrow range gives many equal samples in one window.
      MODE_NARROW: return (smf_pkg::SAMPLE_W)'($urandom_range(6)) - 16'sd3;
      default: begin
        case ($urandom_range(3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  initial begin
    int len;
    int r;
    sample_mode_t mode;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a signal shorter than the window, a one-sample signal.
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'shffff, 1'b1);
    // Zero half width passes the signal through.
    set_half_width(3'd0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b1);
    // An oversized setting acts as the maximum half width.
    set_half_width(3'd7);
    send_sample(16'sh7fff, 1'b1);
    for (int i = 0; i < 10; i++)
      send_sample((i % 3 == 0) ? 16'sh7fff : (i % 3 == 1) ? 16'sh8000 :
                  (smf_pkg::SAMPLE_W)'(i), i == 9);
    set_half_width(3'd4);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd0, 1'b1);
    set_half_width(3'd1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'shffff, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sh5555, 1'b1);

    // Random whole signals, with an occasional new half width between them.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 35) set_half_width((smf_pkg::CFG_W)'($urandom_range(7)));
      r = $urandom_range(99);
      if (r < 15) len = $urandom_range(1, 3);
      else if (r < 75) len = $urandom_range(4, 12);
      else len = $urandom_range(13, 30);
      mode = sample_mode_t'($urandom_range(2));
      calm <= (sent >= 180 && sent < 280);
      for (int i = 0; i < len; i++) send_sample(pick_sample(mode), i == len - 1);
    end
    calm <= 1'b0;

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("sliding_median_filter_mirror: match");
    end else begin
      $display("sliding_median_filter_mirror: mismatch");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("sliding_median_filter_mirror: mismatch");
    $finish;
  end

endmodule

@@ sliding_median_filter_mirror.f @@
+incdir+hdl
hdl/smf_pkg.sv
hdl/smf_sort_cell.sv
hdl/sliding_median_filter_mirror.sv
hdl/smf_checker.sv
tb/smf_checker.sv
tb/tb.sv
